FILE: design/bale_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level estimator package
// Shared widths, constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int unsigned SamplesPerReading = 8;
  localparam int unsigned IdxW = (SamplesPerReading > 1) ? $clog2(SamplesPerReading) : 1;

  localparam int unsigned PinW  = 12;
  localparam int unsigned SumW  = 15;
  localparam int unsigned MvW   = 16;
  localparam int unsigned PctW  = 7;
  localparam int unsigned DivW  = 12;
  localparam int unsigned CalW  = 13;
  localparam int unsigned AlphaW = 9;

  localparam int unsigned MulAW = 24;
  localparam int unsigned MulBW = 13;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned ScaleShift = 20;

  localparam int unsigned NumW   = 24;
  localparam int unsigned DenW   = 16;
  localparam int unsigned DivCntW = $clog2(NumW);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgDividerRatio = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCalibration  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSmoothAlpha  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFullMv       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEmptyMv      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMaxPctStep   = 3'd5;

  localparam logic [DivW-1:0]   DividerReset = 12'd512;
  localparam logic [CalW-1:0]   CalibReset   = 13'd4096;
  localparam logic [AlphaW-1:0] AlphaReset   = 9'd26;
  localparam logic [MvW-1:0]    FullReset    = 16'd4200;
  localparam logic [MvW-1:0]    EmptyReset   = 16'd3300;
  localparam logic [PctW-1:0]   StepReset    = 7'd1;

  localparam logic [MulBW-1:0]  FallbackNum = 13'd3100;
  localparam logic [DenW-1:0]   FallbackDen = 16'd4095;
  localparam int unsigned       FallbackShift = 12;
  localparam logic [AlphaW-1:0] AlphaOne    = 9'd256;
  localparam logic [PctW-1:0]   PctFull     = 7'd100;
  localparam logic [PctW-1:0]   PctLow      = 7'd20;
  localparam logic [PctW-1:0]   PctCritical = 7'd10;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MUL_FB,
    OP_LOAD_FB,
    OP_MUL_DIV,
    OP_MUL_CAL,
    OP_SAT,
    OP_MUL_OLD,
    OP_MUL_NEW,
    OP_BLEND,
    OP_MUL_PCT,
    OP_DIV_PCT,
    OP_STEP,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic pin_zero;
    logic loaded;
    logic between;
    logic div_busy;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

FILE: design/bale_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level estimator sample channel
// Valid/ready channel carrying one ADC sample item.
// ----------------------------------------------------------------------------
interface bale_in_if;
  import bale_pkg::*;

  logic            valid;
  logic            ready;
  logic [PinW-1:0] sample_mv;
  logic [PinW-1:0] fallback_counts;

  modport source (output valid, output sample_mv, output fallback_counts, input ready);
  modport sink (input valid, input sample_mv, input fallback_counts, output ready);
endinterface
`default_nettype wire

FILE: design/bale_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level estimator result channel
// Valid/ready channel carrying one battery reading item.
// ----------------------------------------------------------------------------
interface bale_out_if;
  import bale_pkg::*;

  logic            valid;
  logic            ready;
  logic [PinW-1:0] pin_avg_mv;
  logic [MvW-1:0]  battery_mv;
  logic [PctW-1:0] percent;
  logic            low_flag;
  logic            critical_flag;

  modport source (output valid, output pin_avg_mv, output battery_mv, output percent,
                  output low_flag, output critical_flag, input ready);
  modport sink (input valid, input pin_avg_mv, input battery_mv, input percent,
                input low_flag, input critical_flag, output ready);
endinterface
`default_nettype wire

FILE: design/bale_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level estimator configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bale_cfg_if;
  import bale_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  idx;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface
`default_nettype wire

FILE: design/bale_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level estimator serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bale_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [bale_pkg::NumW-1:0] dividend_i,
  input  wire logic [bale_pkg::DenW-1:0] divisor_i,
  output logic                          busy_o,
  output logic [bale_pkg::NumW-1:0]     quotient_o
);
  import bale_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0]    quo_q, quo_d;
  logic [DenW-1:0]    rem_q, rem_d;
  logic [DenW-1:0]    den_q, den_d;
  logic [DenW:0]      shifted;
  logic [DenW:0]      trial;

  always_comb begin
    shifted = {rem_q, quo_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NumW-2:0], ~trial[DenW]};
      rem_d = trial[DenW] ? shifted[DenW-1:0] : trial[DenW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(NumW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

FILE: design/bale_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level estimator datapath
// Sample accumulation, shared multiplier, filter, percent and result registers.
// ----------------------------------------------------------------------------
module bale_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bale_pkg::cmd_t                cmd_i,
  output bale_pkg::status_t                  status_o,
  input  wire logic [bale_pkg::PinW-1:0]     sample_mv_i,
  input  wire logic [bale_pkg::PinW-1:0]     fallback_counts_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [bale_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bale_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [bale_pkg::PinW-1:0]          out_pin_avg_mv_o,
  output logic [bale_pkg::MvW-1:0]           out_battery_mv_o,
  output logic [bale_pkg::PctW-1:0]          out_percent_o,
  output logic                               out_low_flag_o,
  output logic                               out_critical_flag_o
);
  import bale_pkg::*;

  logic [DivW-1:0]   divider_q;
  logic [CalW-1:0]   calib_q;
  logic [AlphaW-1:0] alpha_q;
  logic [MvW-1:0]    full_q;
  logic [MvW-1:0]    empty_q;
  logic [PctW-1:0]   step_q;

  logic [SumW-1:0]   sum_q;
  logic [IdxW-1:0]   idx_q;
  logic [MvW-1:0]    filt_q;
  logic              loaded_q;
  logic [PctW-1:0]   shown_q;
  logic              out_valid_q;

  logic [PinW-1:0]   pin_q;
  logic [PinW-1:0]   counts_q;
  logic [ProdW-1:0]  prod_q;
  logic [NumW-1:0]   acc_q;
  logic [MvW-1:0]    scaled_q;
  logic [PinW-1:0]   res_pin_q;
  logic [MvW-1:0]    res_mv_q;
  logic [PctW-1:0]   res_pct_q;
  logic              res_low_q;
  logic              res_crit_q;

  logic [SumW-1:0]   sum_next;
  logic              last;
  logic [AlphaW-1:0] alpha_eff;
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  prod_d;
  logic [MvW-1:0]    scaled_d;
  logic [NumW:0]     blend_sum;
  logic [NumW-1:0]   fb_sum;
  logic              at_full;
  logic              at_empty;
  logic [PctW-1:0]   raw_pct;
  logic [PctW-1:0]   diff;
  logic [PctW-1:0]   move;
  logic [PctW-1:0]   shown_d;
  logic              div_start;
  logic [DenW-1:0]   div_den;
  logic              div_busy;
  logic [NumW-1:0]   quotient;

  assign sum_next  = sum_q + SumW'(sample_mv_i);
  assign last      = (idx_q == IdxW'(SamplesPerReading - 1));
  assign alpha_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
  assign at_full   = (filt_q >= full_q);
  assign at_empty  = (filt_q <= empty_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_FB: begin
        mul_a = MulAW'(counts_q);
        mul_b = FallbackNum;
      end
      OP_MUL_DIV: begin
        mul_a = MulAW'(pin_q);
        mul_b = MulBW'(divider_q);
      end
      OP_MUL_CAL: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = calib_q;
      end
      OP_MUL_OLD: begin
        mul_a = MulAW'(filt_q);
        mul_b = MulBW'(AlphaOne - alpha_eff);
      end
      OP_MUL_NEW: begin
        mul_a = MulAW'(scaled_q);
        mul_b = MulBW'(alpha_eff);
      end
      OP_MUL_PCT: begin
        mul_a = MulAW'(filt_q - empty_q);
        mul_b = MulBW'(PctFull);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d    = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};
  assign scaled_d  = prod_q[ProdW-1:ScaleShift+MvW] != '0 ? {MvW{1'b1}}
                                                          : prod_q[ScaleShift+MvW-1:ScaleShift];
  assign blend_sum = {1'b0, acc_q} + {1'b0, prod_q[NumW-1:0]};

  // Division by 4095, one less than 2^12: adding the value shifted down by
  // twelve plus one and shifting down by twelve gives the exact floor while
  // the quotient stays below 4096.
  assign fb_sum = prod_q[NumW-1:0] + NumW'(prod_q[NumW-1:FallbackShift]) + NumW'(1);

  assign div_start = (cmd_i.op == OP_DIV_PCT);
  assign div_den   = full_q - empty_q;

  bale_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[NumW-1:0]),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_comb begin
    if (at_full) begin
      raw_pct = PctFull;
    end else if (at_empty) begin
      raw_pct = '0;
    end else begin
      raw_pct = quotient[PctW-1:0];
    end
    diff = (raw_pct > shown_q) ? (raw_pct - shown_q) : (shown_q - raw_pct);
    move = (diff > step_q) ? step_q : diff;
    if (raw_pct == PctFull) begin
      shown_d = PctFull;
    end else if (raw_pct > shown_q) begin
      shown_d = shown_q + move;
    end else begin
      shown_d = shown_q - move;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q   <= DividerReset;
      calib_q     <= CalibReset;
      alpha_q     <= AlphaReset;
      full_q      <= FullReset;
      empty_q     <= EmptyReset;
      step_q      <= StepReset;
      sum_q       <= '0;
      idx_q       <= '0;
      filt_q      <= '0;
      loaded_q    <= 1'b0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_i)
          CfgDividerRatio: divider_q <= cfg_wdata_i[DivW-1:0];
          CfgCalibration:  calib_q   <= cfg_wdata_i[CalW-1:0];
          CfgSmoothAlpha:  alpha_q   <= cfg_wdata_i[AlphaW-1:0];
          CfgFullMv:       full_q    <= cfg_wdata_i[MvW-1:0];
          CfgEmptyMv:      empty_q   <= cfg_wdata_i[MvW-1:0];
          CfgMaxPctStep:   step_q    <= cfg_wdata_i[PctW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OP_PUBLISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_ACCEPT: begin
          if (last) begin
            sum_q <= '0;
            idx_q <= '0;
          end else begin
            sum_q <= sum_next;
            idx_q <= idx_q + 1'b1;
          end
        end
        OP_SAT: begin
          if (!loaded_q) begin
            filt_q   <= scaled_d;
            loaded_q <= 1'b1;
          end
        end
        OP_BLEND: filt_q <= blend_sum[NumW-1:NumW-MvW];
        OP_STEP: shown_q <= shown_d;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op) inside
      OP_ACCEPT: begin
        pin_q    <= PinW'(sum_next / SumW'(SamplesPerReading));
        counts_q <= fallback_counts_i;
      end
      OP_MUL_FB, OP_MUL_DIV, OP_MUL_CAL, OP_MUL_OLD, OP_MUL_PCT: prod_q <= prod_d;
      OP_MUL_NEW: begin
        acc_q  <= prod_q[NumW-1:0];
        prod_q <= prod_d;
      end
      OP_LOAD_FB: pin_q <= fb_sum[NumW-1:FallbackShift];
      OP_SAT: scaled_q <= scaled_d;
      OP_PUBLISH: begin
        res_pin_q  <= pin_q;
        res_mv_q   <= filt_q;
        res_pct_q  <= shown_q;
        res_low_q  <= (shown_q < PctLow);
        res_crit_q <= (shown_q < PctCritical);
      end
      default: begin
      end
    endcase
  end

  assign status_o.last     = last;
  assign status_o.pin_zero = (pin_q == '0);
  assign status_o.loaded   = loaded_q;
  assign status_o.between  = !at_full && !at_empty;
  assign status_o.div_busy = div_busy;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign out_pin_avg_mv_o    = res_pin_q;
  assign out_battery_mv_o    = res_mv_q;
  assign out_percent_o       = res_pct_q;
  assign out_low_flag_o      = res_low_q;
  assign out_critical_flag_o = res_crit_q;
endmodule
`default_nettype wire

FILE: design/bale_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level estimator controller
// Sequences the datapath through a reading, at most one operation per cycle.
// ----------------------------------------------------------------------------
module bale_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bale_pkg::status_t status_i,
  output bale_pkg::cmd_t         cmd_o
);
  import bale_pkg::*;

  localparam logic [4:0] SIdle    = 5'd0;
  localparam logic [4:0] SCheck   = 5'd1;
  localparam logic [4:0] SFbMul   = 5'd2;
  localparam logic [4:0] SFbLoad  = 5'd5;
  localparam logic [4:0] SMulDiv  = 5'd6;
  localparam logic [4:0] SMulCal  = 5'd7;
  localparam logic [4:0] SSat     = 5'd8;
  localparam logic [4:0] SMulOld  = 5'd9;
  localparam logic [4:0] SMulNew  = 5'd10;
  localparam logic [4:0] SBlend   = 5'd11;
  localparam logic [4:0] SClass   = 5'd12;
  localparam logic [4:0] SMulPct  = 5'd13;
  localparam logic [4:0] SDivPct  = 5'd14;
  localparam logic [4:0] SPctWait = 5'd15;
  localparam logic [4:0] SStep    = 5'd16;
  localparam logic [4:0] SPublish = 5'd17;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (status_i.last) begin
            state_d = SCheck;
          end
        end
      end
      SCheck: state_d = status_i.pin_zero ? SFbMul : SMulDiv;
      SFbMul: begin
        cmd_o.op = OP_MUL_FB;
        state_d  = SFbLoad;
      end
      SFbLoad: begin
        cmd_o.op = OP_LOAD_FB;
        state_d  = SMulDiv;
      end
      SMulDiv: begin
        cmd_o.op = OP_MUL_DIV;
        state_d  = SMulCal;
      end
      SMulCal: begin
        cmd_o.op = OP_MUL_CAL;
        state_d  = SSat;
      end
      SSat: begin
        cmd_o.op = OP_SAT;
        state_d  = status_i.loaded ? SMulOld : SClass;
      end
      SMulOld: begin
        cmd_o.op = OP_MUL_OLD;
        state_d  = SMulNew;
      end
      SMulNew: begin
        cmd_o.op = OP_MUL_NEW;
        state_d  = SBlend;
      end
      SBlend: begin
        cmd_o.op = OP_BLEND;
        state_d  = SClass;
      end
      SClass: state_d = status_i.between ? SMulPct : SStep;
      SMulPct: begin
        cmd_o.op = OP_MUL_PCT;
        state_d  = SDivPct;
      end
      SDivPct: begin
        cmd_o.op = OP_DIV_PCT;
        state_d  = SPctWait;
      end
      SPctWait: begin
        if (!status_i.div_busy) begin
          state_d = SStep;
        end
      end
      SStep: begin
        cmd_o.op = OP_STEP;
        state_d  = SPublish;
      end
      SPublish: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_PUBLISH;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

FILE: design/battery_level_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery level estimator
// Averages ADC pin samples into smoothed battery voltage and charge percent.
// ----------------------------------------------------------------------------
// Every eighth sample item ends a reading and produces one result item; the
// other samples are taken as they arrive, with ready held high. After the
// last sample of a reading is taken, the block takes no sample until the
// result is published; when the pin average is zero the fallback counts are
// first scaled with a multiply and a shift and add. The first reading skips
// the filter steps (old-value multiply, new-value multiply, blend), and a
// voltage at or outside the thresholds skips the percent multiplication and
// the 24-step serial divider. All multiplications go through a single shared
// multiplier. A finished result waits in an output register while new samples
// are accepted; publishing the next result waits until that register has been
// taken. Configuration writes are taken at any time and should be made while no reading is in progress.
module battery_level_estimator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bale_in_if.sink     in_i,
  bale_out_if.source  out_o,
  bale_cfg_if.sink    cfg_i
);
  import bale_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  bale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bale_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .sample_mv_i         (in_i.sample_mv),
    .fallback_counts_i   (in_i.fallback_counts),
    .cfg_valid_i         (cfg_i.valid),
    .cfg_idx_i           (cfg_i.idx),
    .cfg_wdata_i         (cfg_i.wdata),
    .out_ready_i         (out_o.ready),
    .out_valid_o         (out_o.valid),
    .out_pin_avg_mv_o    (out_o.pin_avg_mv),
    .out_battery_mv_o    (out_o.battery_mv),
    .out_percent_o       (out_o.percent),
    .out_low_flag_o      (out_o.low_flag),
    .out_critical_flag_o (out_o.critical_flag)
  );
endmodule
`default_nettype wire
